// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the core.
// Depends on nothing; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted (active-low reset).
`define ASSERT_CLKRST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/mntr_pkg.sv -----
// Shared types and constants of the motion/noise level tracker core.
// Used by every module in rtl/core; depends on nothing.
package mntr_pkg;

    // Ring geometry: depth is a power of two by construction
    localparam int RING_AW    = 4;
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

    // Filter gains
    localparam int IIR_SHIFT          = 4;
    localparam int NOISE_SMOOTH_SHIFT = 8;

    // Datapath widths
    localparam int MAG_W    = 16;
    localparam int SUM_W    = MAG_W + RING_AW + 1;
    localparam int IIR_W    = MAG_W + IIR_SHIFT;
    localparam int SN_W     = MAG_W + NOISE_SMOOTH_SHIFT;
    localparam int NOISE_W  = 14;
    localparam int MOTION_W = 21;
    localparam int NSHIFT_W = 3;

    // Fixed constants
    localparam logic [MAG_W-1:0]   ONE_G              = 16'h4000;
    localparam logic [NOISE_W-1:0] NOISE_CEIL         = 14'h3FFF;
    localparam logic [MAG_W-1:0]   NOISE_MARGIN_RESET = 16'h0230;
    localparam int                 MOTION_SCALE_SHIFT = 5;

    // Config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MOTION_W;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MARGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SHIFT   = 2'd2;

    // Command queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [0:0] {
        OP_SAMPLE  = 1'b0,
        OP_PRELOAD = 1'b1
    } op_t;

    typedef struct packed {
        logic             kind;
        logic [MAG_W-1:0] magnitude;
    } in_word_t;

    typedef struct packed {
        logic [MAG_W-1:0]    mean_level;
        logic [NOISE_W-1:0]  noise_score;
        logic [MOTION_W-1:0] motion_level;
    } out_word_t;

    typedef struct packed {
        op_t              op;
        logic [MAG_W-1:0] magnitude;
    } cmd_t;

    typedef struct packed {
        logic [MAG_W-1:0]    noise_margin;
        logic [MOTION_W-1:0] motion_margin;
        logic [NSHIFT_W-1:0] noise_shift;
    } cfg_t;

endpackage

// ----- rtl/core/motion_noise_level_tracker_core.sv -----
// A sample word gives a result word; on every 16th sample the transfer ring is
// first averaged into the long-term ring. A preload sweeps the rings in the back
// end and gives no result. The back end takes a new command only once it is done
// with the last one; its scan over the ring registers goes one index per cycle.
// Reset (aresetn, synchronous, active low) clears rings, pointers, filters and
// the queue at once and loads the config registers with their defaults.
module motion_noise_level_tracker_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  mntr_pkg::in_word_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mntr_pkg::out_word_t                   m_data,
    input  logic                                  cfg_we,
    input  logic [mntr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mntr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    mntr_pkg::cfg_t cfg_reg, cfg_next;
    mntr_pkg::cmd_t cmd;
    logic           cmd_valid, cmd_ready;

    // Config register writes; unknown index is dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                mntr_pkg::CFG_NOISE_MARGIN:
                    cfg_next.noise_margin = cfg_wdata[mntr_pkg::MAG_W-1:0];
                mntr_pkg::CFG_MOTION_MARGIN:
                    cfg_next.motion_margin = cfg_wdata[mntr_pkg::MOTION_W-1:0];
                mntr_pkg::CFG_NOISE_SHIFT:
                    cfg_next.noise_shift = cfg_wdata[mntr_pkg::NSHIFT_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.noise_margin  <= mntr_pkg::NOISE_MARGIN_RESET;
            cfg_reg.motion_margin <= '0;
            cfg_reg.noise_shift   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mntr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mntr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- rtl/core/mntr_front.sv -----
// Front end: accepts input words, decodes them into commands and queues them.
// Depends on mntr_pkg.
module mntr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mntr_pkg::in_word_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output mntr_pkg::cmd_t    cmd
);

    mntr_pkg::cmd_t                 slot_reg [mntr_pkg::QUEUE_DEPTH];
    logic [mntr_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [mntr_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [mntr_pkg::QUEUE_AW:0]    count_reg, count_next;
    mntr_pkg::cmd_t                 new_cmd;
    logic                           push, pop;

    // Classify the incoming word
    always_comb begin
        new_cmd.op        = s_data.kind ? mntr_pkg::OP_PRELOAD : mntr_pkg::OP_SAMPLE;
        new_cmd.magnitude = s_data.magnitude;
    end

    assign s_ready   = (count_reg != (mntr_pkg::QUEUE_AW + 1)'(mntr_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + (mntr_pkg::QUEUE_AW)'(push);
        rd_ptr_next = rd_ptr_reg + (mntr_pkg::QUEUE_AW)'(pop);
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- rtl/core/mntr_back.sv -----
// Back end: ring bookkeeping, sum/deviation scan, filters and result register.
// Depends on mntr_pkg.
module mntr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  mntr_pkg::cmd_t      cmd,
    input  mntr_pkg::cfg_t      cfg,
    output logic                m_valid,
    input  logic                m_ready,
    output mntr_pkg::out_word_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_MOVE,
        ST_TSUM,
        ST_SCAN,
        ST_FIN,
        ST_OUT
    } state_t;

    localparam int MW = mntr_pkg::MAG_W;
    localparam int AW = mntr_pkg::RING_AW;

    function automatic logic [MW-1:0] abs_diff(input logic [MW-1:0] a, input logic [MW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Ring storage: one read address per ring
    logic [MW-1:0] recent_reg   [mntr_pkg::RING_DEPTH];
    logic [MW-1:0] transfer_reg [mntr_pkg::RING_DEPTH];
    logic [MW-1:0] long_reg     [mntr_pkg::RING_DEPTH];

    state_t                       state_reg, state_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [AW-1:0]                rp_reg, rp_next;
    logic [AW-1:0]                tp_reg, tp_next;
    logic [AW-1:0]                lp_reg, lp_next;
    logic [mntr_pkg::IIR_W-1:0]   iir_reg, iir_next;
    logic [MW-1:0]                pm_reg, pm_next;
    logic [mntr_pkg::SN_W-1:0]    sn_reg, sn_next;
    logic [mntr_pkg::SUM_W-1:0]   acc_reg, acc_next;
    logic [mntr_pkg::SUM_W-1:0]   dev_reg, dev_next;
    logic [MW-1:0]                mag_reg, mag_next;
    logic                         m_valid_reg, m_valid_next;
    mntr_pkg::out_word_t          m_data_reg, m_data_next;

    // Ring port signals
    logic [AW-1:0] recent_raddr;
    logic [MW-1:0] recent_rd, transfer_rd, long_rd;
    logic          recent_we, transfer_we, long_we;
    logic [AW-1:0] recent_waddr, transfer_waddr, long_waddr;
    logic [MW-1:0] recent_wdata, transfer_wdata, long_wdata;

    // Result terms
    logic [MW-1:0]                 noise_raw, noise_sub, noise_sh, avg, motion_diff;
    logic [mntr_pkg::MOTION_W-1:0] motion_scaled;
    mntr_pkg::out_word_t           result;
    logic [mntr_pkg::SUM_W-1:0]    tsum;

    assign recent_raddr = (state_reg == ST_MOVE) ? rp_reg : idx_reg;
    assign recent_rd    = recent_reg[recent_raddr];
    assign transfer_rd  = transfer_reg[idx_reg];
    assign long_rd      = long_reg[idx_reg];
    assign tsum         = acc_reg + mntr_pkg::SUM_W'(transfer_rd);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Noise and motion from the filter registers
    always_comb begin
        noise_raw   = sn_reg[mntr_pkg::NOISE_SMOOTH_SHIFT +: MW];
        noise_sub   = (noise_raw > cfg.noise_margin) ? (noise_raw - cfg.noise_margin) : '0;
        noise_sh    = noise_sub >> cfg.noise_shift;
        avg         = iir_reg[mntr_pkg::IIR_SHIFT +: MW];
        motion_diff = abs_diff(avg, mntr_pkg::ONE_G);
        motion_scaled = {motion_diff, {mntr_pkg::MOTION_SCALE_SHIFT{1'b0}}};
        result.mean_level  = pm_reg;
        result.noise_score = (noise_sh > MW'(mntr_pkg::NOISE_CEIL))
                           ? mntr_pkg::NOISE_CEIL : noise_sh[mntr_pkg::NOISE_W-1:0];
        result.motion_level = (motion_scaled > cfg.motion_margin)
                            ? (motion_scaled - cfg.motion_margin) : '0;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        rp_next      = rp_reg;
        tp_next      = tp_reg;
        lp_next      = lp_reg;
        iir_next     = iir_reg;
        pm_next      = pm_reg;
        sn_next      = sn_reg;
        acc_next     = acc_reg;
        dev_next     = dev_reg;
        mag_next     = mag_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        recent_we      = 1'b0;
        transfer_we    = 1'b0;
        long_we        = 1'b0;
        recent_waddr   = idx_reg;
        transfer_waddr = idx_reg;
        long_waddr     = idx_reg;
        recent_wdata   = mag_reg;
        transfer_wdata = mag_reg;
        long_wdata     = mag_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    mag_next = cmd.magnitude;
                    idx_next = '0;
                    if (cmd.op == mntr_pkg::OP_PRELOAD) begin
                        iir_next   = mntr_pkg::IIR_W'(cmd.magnitude) << mntr_pkg::IIR_SHIFT;
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_MOVE;
                    end
                end
            end
            // Preload sweep: one entry of each ring per cycle
            ST_FILL: begin
                recent_we   = 1'b1;
                transfer_we = 1'b1;
                long_we     = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == mntr_pkg::RING_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            // Oldest recent sample moves to the transfer ring, new sample enters
            ST_MOVE: begin
                transfer_we    = 1'b1;
                transfer_waddr = tp_reg;
                transfer_wdata = recent_rd;
                recent_we      = 1'b1;
                recent_waddr   = rp_reg;
                rp_next        = rp_reg + 1'b1;
                tp_next        = tp_reg + 1'b1;
                iir_next       = iir_reg - (iir_reg >> mntr_pkg::IIR_SHIFT)
                               + mntr_pkg::IIR_W'(mag_reg);
                acc_next       = '0;
                dev_next       = '0;
                idx_next       = '0;
                state_next     = (tp_reg == mntr_pkg::RING_LAST) ? ST_TSUM : ST_SCAN;
            end
            // Transfer ring full: its mean goes into the long-term ring
            ST_TSUM: begin
                acc_next = tsum;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == mntr_pkg::RING_LAST) begin
                    long_we    = 1'b1;
                    long_waddr = lp_reg;
                    long_wdata = tsum[AW +: MW];
                    lp_next    = lp_reg + 1'b1;
                    acc_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            // Sum and deviation over both rings, one index per cycle
            ST_SCAN: begin
                acc_next = acc_reg + mntr_pkg::SUM_W'(recent_rd) + mntr_pkg::SUM_W'(long_rd);
                dev_next = dev_reg + mntr_pkg::SUM_W'(abs_diff(recent_rd, pm_reg))
                         + mntr_pkg::SUM_W'(abs_diff(long_rd, pm_reg));
                idx_next = idx_reg + 1'b1;
                if (idx_reg == mntr_pkg::RING_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                pm_next    = acc_reg[AW+1 +: MW];
                sn_next    = sn_reg - (sn_reg >> mntr_pkg::NOISE_SMOOTH_SHIFT)
                           + mntr_pkg::SN_W'(dev_reg[AW+1 +: MW]);
                state_next = ST_OUT;
            end
            // Wait for a free result register
            ST_OUT: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            rp_reg      <= '0;
            tp_reg      <= '0;
            lp_reg      <= '0;
            iir_reg     <= '0;
            pm_reg      <= '0;
            sn_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rp_reg      <= rp_next;
            tp_reg      <= tp_next;
            lp_reg      <= lp_next;
            iir_reg     <= iir_next;
            pm_reg      <= pm_next;
            sn_reg      <= sn_next;
            m_valid_reg <= m_valid_next;
        end
        acc_reg    <= acc_next;
        dev_reg    <= dev_next;
        mag_reg    <= mag_next;
        m_data_reg <= m_data_next;
    end

    // Ring registers, cleared to zero at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mntr_pkg::RING_DEPTH; i++) begin
                recent_reg[i]   <= '0;
                transfer_reg[i] <= '0;
                long_reg[i]     <= '0;
            end
        end else begin
            if (recent_we) begin
                recent_reg[recent_waddr] <= recent_wdata;
            end
            if (transfer_we) begin
                transfer_reg[transfer_waddr] <= transfer_wdata;
            end
            if (long_we) begin
                long_reg[long_waddr] <= long_wdata;
            end
        end
    end

endmodule

// ----- rtl/core/mntr_checker.sv -----
// Port-level checks for the tracker core, bound to the top level.
// Depends on mntr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mntr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mntr_pkg::out_word_t m_data
);

    // A waiting result word holds until taken
    `ASSERT_CLKRST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word changed while stalled")
    // Result register is empty in the cycle after a word is taken
    `ASSERT_CLKRST(a_out_gap, aclk, aresetn, m_valid && m_ready |=> !m_valid, "result words back to back")
    // Reset empties the result register
    `ASSERT_CLK(a_rst_out, aclk, !aresetn |=> !m_valid, "result valid after reset")
    // Reset empties the queue so input is accepted
    `ASSERT_CLK(a_rst_in, aclk, !aresetn |=> s_ready, "input not ready after reset")

endmodule

bind motion_noise_level_tracker_core mntr_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- verif/motion_noise_level_tracker_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for motion_noise_level_tracker_core: random handshake gaps on both
// channels, a scoreboard class that mirrors the rings, filters and registers per word.
// Depends on rtl/core/mntr_pkg.sv and the core itself.
module motion_noise_level_tracker_core_tb;

    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 238;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 3000;
    // unmapped index, must be ignored
    localparam logic [mntr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Mirror of the tracker state and the queue of result words still owed
    class level_scoreboard;
        logic [mntr_pkg::MAG_W-1:0] fresh_hist [mntr_pkg::RING_DEPTH];
        logic [mntr_pkg::MAG_W-1:0] carry_hist [mntr_pkg::RING_DEPTH];
        logic [mntr_pkg::MAG_W-1:0] slow_hist  [mntr_pkg::RING_DEPTH];
        int unsigned fresh_pos, carry_pos, slow_pos;
        int unsigned iir_acc, last_mean, noise_acc;
        int unsigned noise_floor, motion_floor, noise_rshift;
        mntr_pkg::out_word_t owed_words [$];
        int unsigned error_count, checked_count;

        function new();
            foreach (fresh_hist[i]) begin
                fresh_hist[i] = '0;
                carry_hist[i] = '0;
                slow_hist[i]  = '0;
            end
            fresh_pos    = 0;
            carry_pos    = 0;
            slow_pos     = 0;
            iir_acc      = 0;
            last_mean    = 0;
            noise_acc    = 0;
            noise_floor  = mntr_pkg::NOISE_MARGIN_RESET;
            motion_floor = 0;
            noise_rshift = 0;
            error_count  = 0;
            checked_count = 0;
        endfunction

        function int unsigned abs_gap(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        // Register writes are masked to the register width; unmapped index is dropped
        function void write_reg(logic [mntr_pkg::CFG_IDX_W-1:0] idx,
                                logic [mntr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mntr_pkg::CFG_NOISE_MARGIN:  noise_floor  = data[mntr_pkg::MAG_W-1:0];
                mntr_pkg::CFG_MOTION_MARGIN: motion_floor = data[mntr_pkg::MOTION_W-1:0];
                mntr_pkg::CFG_NOISE_SHIFT:   noise_rshift = data[mntr_pkg::NSHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_word(mntr_pkg::in_word_t w);
            int unsigned total, spread, lvl, avg, mot;
            mntr_pkg::out_word_t want;
            // preload: flood all history and the IIR, no result word
            if (w.kind == mntr_pkg::OP_PRELOAD) begin
                foreach (fresh_hist[i]) begin
                    fresh_hist[i] = w.magnitude;
                    carry_hist[i] = w.magnitude;
                    slow_hist[i]  = w.magnitude;
                end
                iir_acc = 32'(w.magnitude) << mntr_pkg::IIR_SHIFT;
                return;
            end
            // displaced recent entry moves to the transfer ring; full ring -> long-term mean
            carry_hist[carry_pos] = fresh_hist[fresh_pos];
            carry_pos++;
            if (carry_pos == mntr_pkg::RING_DEPTH) begin
                total = 0;
                foreach (carry_hist[i]) total += carry_hist[i];
                slow_hist[slow_pos] = mntr_pkg::MAG_W'(total / mntr_pkg::RING_DEPTH);
                slow_pos  = (slow_pos + 1) % mntr_pkg::RING_DEPTH;
                carry_pos = 0;
            end
            fresh_hist[fresh_pos] = w.magnitude;
            fresh_pos = (fresh_pos + 1) % mntr_pkg::RING_DEPTH;
            iir_acc = iir_acc - (iir_acc >> mntr_pkg::IIR_SHIFT) + w.magnitude;
            // mean and deviation, deviation taken against the previous word's mean
            total  = 0;
            spread = 0;
            for (int i = 0; i < mntr_pkg::RING_DEPTH; i++) begin
                total  += fresh_hist[i] + slow_hist[i];
                spread += abs_gap(fresh_hist[i], last_mean) + abs_gap(slow_hist[i], last_mean);
            end
            last_mean = (total / (2 * mntr_pkg::RING_DEPTH)) & 32'hFFFF;
            spread    = spread / (2 * mntr_pkg::RING_DEPTH);
            // smoothed noise, margin floor, shift, saturate
            noise_acc = noise_acc - (noise_acc >> mntr_pkg::NOISE_SMOOTH_SHIFT) + spread;
            lvl = noise_acc >> mntr_pkg::NOISE_SMOOTH_SHIFT;
            lvl = (lvl > noise_floor) ? lvl - noise_floor : 0;
            lvl = lvl >> noise_rshift;
            if (lvl > mntr_pkg::NOISE_CEIL) lvl = mntr_pkg::NOISE_CEIL;
            // motion: distance of IIR average from 1 g, scaled, minus margin
            avg = iir_acc >> mntr_pkg::IIR_SHIFT;
            mot = abs_gap(avg, mntr_pkg::ONE_G) << mntr_pkg::MOTION_SCALE_SHIFT;
            mot = (mot > motion_floor) ? mot - motion_floor : 0;
            want.mean_level   = mntr_pkg::MAG_W'(last_mean);
            want.noise_score  = mntr_pkg::NOISE_W'(lvl);
            want.motion_level = mntr_pkg::MOTION_W'(mot);
            owed_words.push_back(want);
        endfunction

        function void check_word(mntr_pkg::out_word_t got);
            mntr_pkg::out_word_t want;
            if (owed_words.size() == 0) begin
                $error("result word %h arrived with nothing owed", got);
                error_count++;
                return;
            end
            want = owed_words.pop_front();
            checked_count++;
            if (got.mean_level !== want.mean_level) begin
                $error("mean_level: expected %0d, got %0d", want.mean_level, got.mean_level);
                error_count++;
            end
            if (got.noise_score !== want.noise_score) begin
                $error("noise_score: expected %0d, got %0d", want.noise_score, got.noise_score);
                error_count++;
            end
            if (got.motion_level !== want.motion_level) begin
                $error("motion_level: expected %0d, got %0d",
                       want.motion_level, got.motion_level);
                error_count++;
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    mntr_pkg::in_word_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    mntr_pkg::out_word_t             m_data;
    logic                            cfg_we;
    logic [mntr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mntr_pkg::CFG_DATA_W-1:0] cfg_wdata;

    level_scoreboard tracker = new();
    bit          src_no_gaps, sink_no_gaps, hold_request;
    int unsigned samples_sent, preloads_sent, reg_writes, stall_count;

    // Short opening sequence under reset defaults: extremes, 1 g, back-to-back preloads
    mntr_pkg::in_word_t opening_words [24] = '{
        '{mntr_pkg::OP_SAMPLE, 16'h0000},  '{mntr_pkg::OP_SAMPLE, 16'hFFFF},
        '{mntr_pkg::OP_SAMPLE, 16'h4000},  '{mntr_pkg::OP_PRELOAD, 16'hFFFF},
        '{mntr_pkg::OP_SAMPLE, 16'hFFFF},  '{mntr_pkg::OP_SAMPLE, 16'h0000},
        '{mntr_pkg::OP_PRELOAD, 16'h4000}, '{mntr_pkg::OP_SAMPLE, 16'h4000},
        '{mntr_pkg::OP_SAMPLE, 16'h4001},  '{mntr_pkg::OP_SAMPLE, 16'h3FFF},
        '{mntr_pkg::OP_PRELOAD, 16'h0000}, '{mntr_pkg::OP_PRELOAD, 16'hFFFF},
        '{mntr_pkg::OP_SAMPLE, 16'hAAAA},  '{mntr_pkg::OP_SAMPLE, 16'h5555},
        '{mntr_pkg::OP_PRELOAD, 16'h0000}, '{mntr_pkg::OP_SAMPLE, 16'h0000},
        '{mntr_pkg::OP_SAMPLE, 16'h8000},  '{mntr_pkg::OP_SAMPLE, 16'h7FFF},
        '{mntr_pkg::OP_SAMPLE, 16'h0001},  '{mntr_pkg::OP_SAMPLE, 16'hFFFE},
        '{mntr_pkg::OP_SAMPLE, 16'h1234},  '{mntr_pkg::OP_SAMPLE, 16'hEDCB},
        '{mntr_pkg::OP_SAMPLE, 16'h4000},  '{mntr_pkg::OP_SAMPLE, 16'hC000}
    };

    motion_noise_level_tracker_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one word; entered and left at a falling edge, valid kept high when no gap
    task automatic send_word(mntr_pkg::in_word_t w);
        int unsigned gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        tracker.note_word(w);
        if (w.kind == mntr_pkg::OP_PRELOAD) preloads_sent++;
        else samples_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [mntr_pkg::CFG_IDX_W-1:0] idx,
                             logic [mntr_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        tracker.write_reg(idx, data);
        reg_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Drop valid and wait for every owed word, then let a trailing preload finish
    task automatic quiesce();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Stimulus: opening words, then phases of random words under changing registers
    initial begin : stimulus
        mntr_pkg::in_word_t w;
        int unsigned        amp, pick;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening_words[i]) send_word(opening_words[i]);

        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            quiesce();
            case (phase)
                1: begin
                    write_reg(mntr_pkg::CFG_NOISE_MARGIN, '0);
                    write_reg(mntr_pkg::CFG_MOTION_MARGIN, '0);
                    write_reg(mntr_pkg::CFG_NOISE_SHIFT, '0);
                    write_reg(CFG_SPARE, 21'h1FFFFF);
                end
                2: begin
                    write_reg(mntr_pkg::CFG_NOISE_MARGIN, 21'h1FFFFF);
                    write_reg(mntr_pkg::CFG_MOTION_MARGIN, 21'h1FFFFF);
                    write_reg(mntr_pkg::CFG_NOISE_SHIFT, 21'h1FFFFF);
                end
                3: begin
                    // upper data bits set, masked away by the register width
                    write_reg(mntr_pkg::CFG_NOISE_MARGIN, 21'h1F0000);
                    write_reg(mntr_pkg::CFG_MOTION_MARGIN, 21'd31);
                    write_reg(mntr_pkg::CFG_NOISE_SHIFT, 21'h00000B);
                end
                default: begin
                    write_reg(mntr_pkg::CFG_NOISE_MARGIN,
                              mntr_pkg::CFG_DATA_W'($urandom_range(0, 1500)
                                                    | ($urandom_range(0, 31) << 16)));
                    write_reg(mntr_pkg::CFG_MOTION_MARGIN,
                              mntr_pkg::CFG_DATA_W'($urandom_range(0, 21'h1FFFF)));
                    write_reg(mntr_pkg::CFG_NOISE_SHIFT,
                              mntr_pkg::CFG_DATA_W'($urandom_range(0, 21'h1FFFFF)));
                    write_reg(CFG_SPARE, mntr_pkg::CFG_DATA_W'($urandom_range(0, 21'h1FFFFF)));
                end
            endcase
            src_no_gaps  = (phase == 3);
            sink_no_gaps = (phase == 3 || phase == 5);
            amp = 32 << phase;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver stall while words keep coming
                if (phase == 2 && n == 40) hold_request = 1'b1;
                // sender pauses until the pipeline has drained
                if (phase == 4 && n == PHASE_ITEMS / 2) quiesce();
                w.kind = ($urandom_range(0, 99) < 4) ? mntr_pkg::OP_PRELOAD
                                                     : mntr_pkg::OP_SAMPLE;
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    w.magnitude = mntr_pkg::MAG_W'(32'h4000 + $urandom_range(0, 2 * amp) - amp);
                end else if (pick < 75) begin
                    w.magnitude = mntr_pkg::MAG_W'($urandom_range(0, 16'hFFFF));
                end else if (pick < 88) begin
                    case ($urandom_range(0, 4))
                        0:       w.magnitude = 16'h0000;
                        1:       w.magnitude = 16'hFFFF;
                        2:       w.magnitude = mntr_pkg::ONE_G;
                        3:       w.magnitude = mntr_pkg::ONE_G - 1;
                        default: w.magnitude = mntr_pkg::ONE_G + 1;
                    endcase
                end else begin
                    // hard swings between both ends of the range
                    w.magnitude = $urandom_range(0, 1)
                                ? mntr_pkg::MAG_W'($urandom_range(0, 16'h0FFF))
                                : mntr_pkg::MAG_W'($urandom_range(16'hF000, 16'hFFFF));
                end
                send_word(w);
            end
        end
        quiesce();

        $display("run covered %0d samples and %0d preloads over %0d register settings",
                 samples_sent, preloads_sent, NUM_PHASES + 1);
        $display("%0d result words checked, %0d register writes, %0d mismatches",
                 tracker.checked_count, reg_writes, tracker.error_count);
        if (tracker.error_count == 0 && tracker.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Result side: random ready gaps, one long hold on request
    initial begin : result_sink
        int unsigned gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = sink_no_gaps ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_word(m_data);
            @(negedge aclk);
        end
    end

    // Watchdog: too long without any word or register write moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count == STALL_LIMIT) begin
                $display("timeout after %0d idle cycles, %0d words owed",
                         STALL_LIMIT, tracker.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mntr_pkg.sv
rtl/core/mntr_front.sv
rtl/core/mntr_back.sv
rtl/core/motion_noise_level_tracker_core.sv
rtl/core/mntr_checker.sv
verif/motion_noise_level_tracker_core_tb.sv
